/* hdl/dam_pkg.sv */
// ----------------------------------------------------------------------------
// dam_pkg: shared types and constants of the DRAM address mapper
// Configuration and result records, slot layout tables and the address
// bit pick used by the decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

package dam_pkg;

	// Address and position widths
	localparam int ADDR_BITS = 40;
	localparam int AIDX_W    = $clog2(ADDR_BITS);
	localparam int POS_W     = 6;
	localparam int FW_W      = 5;
	localparam int NUM_FIELDS = 10;
	localparam int NUM_SLOTS  = 50;
	localparam int SLOTS_PER_REG = 10;
	localparam int HASH_TAPS  = 18;
	localparam int TAPS_PER_REG = 9;
	localparam int MAX_FW     = 18;
	localparam int TOTAL_W    = 6;
	localparam int CFG_DATA_W = 60;
	localparam int CFG_IDX_W  = 3;
	localparam int HASH_EN_BIT = 50;

	// Field numbers in slot order
	localparam int F_CHANNEL  = 0;
	localparam int F_SUB      = 1;
	localparam int F_PSEUDO   = 2;
	localparam int F_RANK     = 3;
	localparam int F_CID      = 4;
	localparam int F_BG       = 5;
	localparam int F_BANK     = 6;
	localparam int F_ROW      = 7;
	localparam int F_COLUMN   = 8;
	localparam int F_BYTE     = 9;

	// First slot and slot count of each field
	localparam int SLOT_BASE [NUM_FIELDS] = '{0, 2, 3, 4, 6, 9, 12, 14, 32, 43};
	localparam int SLOT_MAX  [NUM_FIELDS] = '{2, 1, 1, 2, 3, 3, 2, 18, 11, 7};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_WIDTHS = 3'd0,
		REG_SLOTS_A      = 3'd1,
		REG_SLOTS_B      = 3'd2,
		REG_SLOTS_C      = 3'd3,
		REG_SLOTS_D      = 3'd4,
		REG_SLOTS_E      = 3'd5,
		REG_TAPS_LOW     = 3'd6,
		REG_TAPS_HIGH    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [50:0]       field_widths;
		logic [4:0][59:0]  slots;
		logic [1:0][53:0]  taps;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  channel;
		logic        sub_ch;
		logic        pseudo_ch;
		logic [1:0]  rank;
		logic [2:0]  chip_id;
		logic [2:0]  bank_group;
		logic [1:0]  bank;
		logic [17:0] row;
		logic [10:0] column;
		logic [6:0]  byte_offset;
		logic [9:0]  flat_bank;
		logic        out_of_range;
	} res_t;

	// Pick one address bit; positions past the address width read as zero
	function automatic logic bit_at(input logic [ADDR_BITS-1:0] a,
			input logic [POS_W-1:0] pos);
		logic r;
		r = 1'b0;
		if (int'(pos) < ADDR_BITS) begin
			r = a[pos[AIDX_W-1:0]];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/dram_address_mapper_bank_hash_top.sv */
// ----------------------------------------------------------------------------
// dram_address_mapper_bank_hash_top: DRAM address mapper with XOR bank hash
// Decodes one flat physical address per item into DRAM coordinates, a flat
// bank index and an out-of-range flag.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              payload
//  in_*         in   in_valid / in_ready    address
//  out_*        out  out_valid / out_ready  channel .. byte_offset, flat_bank,
//                                           out_of_range
//  cfg_*        in   cfg_we                 cfg_index, cfg_wdata
//
//  An accepted item waits in the input register and moves to the result register
//  once that is free or being drained; one item per cycle is taken while the output side keeps up.
//  The input register and the result register each hold one item, so an item
//  is taken while a finished result waits; in_ready drops only when both are
//  full and out_ready is low.
//  Reset clears the configuration registers and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dram_address_mapper_bank_hash_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output      logic                             in_ready,
	input  wire logic [dam_pkg::ADDR_BITS-1:0]    address,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic [1:0]                       channel,
	output      logic                             sub_ch,
	output      logic                             pseudo_ch,
	output      logic [1:0]                       rank,
	output      logic [2:0]                       chip_id,
	output      logic [2:0]                       bank_group,
	output      logic [1:0]                       bank,
	output      logic [17:0]                      row,
	output      logic [10:0]                      column,
	output      logic [6:0]                       byte_offset,
	output      logic [9:0]                       flat_bank,
	output      logic                             out_of_range,
	input  wire logic                             cfg_we,
	input  wire logic [dam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dam_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	dam_pkg::cfg_t                    cfg;
	dam_pkg::res_t                    res_d;
	dam_pkg::res_t                    res_s2;
	logic [dam_pkg::ADDR_BITS-1:0]    addr_s1;
	logic                             valid_s1;
	logic                             valid_s2;
	logic                             adv_s1;

	dam_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dam_decode u_decode (
		.cfg  (cfg),
		.addr (addr_s1),
		.res  (res_d)
	);

	// Advance stage one when the result register is free or being drained
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	// Track valid items in both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Load the address and the decoded result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_s1 <= address;
		end
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// Drive the output channel
	assign out_valid      = valid_s2;
	assign channel        = res_s2.channel;
	assign sub_ch         = res_s2.sub_ch;
	assign pseudo_ch      = res_s2.pseudo_ch;
	assign rank           = res_s2.rank;
	assign chip_id        = res_s2.chip_id;
	assign bank_group     = res_s2.bank_group;
	assign bank           = res_s2.bank;
	assign row            = res_s2.row;
	assign column         = res_s2.column;
	assign byte_offset    = res_s2.byte_offset;
	assign flat_bank      = res_s2.flat_bank;
	assign out_of_range   = res_s2.out_of_range;

	// Input stalls only when both stages hold an item and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a full pipeline");

	// An accepted item lands in stage one
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted item lost before stage one");

	// A held stage-one item keeps its address
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(addr_s1)))
		else $error("stalled stage-one item changed");

	// An advancing item reaches the result register
	a_adv_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> out_valid)
		else $error("advancing item did not reach the output");

endmodule

`default_nettype wire

/* hdl/dam_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dam_cfg_regs: configuration register file
// Holds field widths, hash enable, slot positions and hash tap positions.
// ----------------------------------------------------------------------------
`default_nettype none

module dam_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dam_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output dam_pkg::cfg_t                         cfg
);

	dam_pkg::cfg_t cfg_q;

	// Write the addressed register, truncated to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (dam_pkg::reg_idx_t'(cfg_index))
				dam_pkg::REG_FIELD_WIDTHS: cfg_q.field_widths <= cfg_wdata[50:0];
				dam_pkg::REG_SLOTS_A:      cfg_q.slots[0]     <= cfg_wdata;
				dam_pkg::REG_SLOTS_B:      cfg_q.slots[1]     <= cfg_wdata;
				dam_pkg::REG_SLOTS_C:      cfg_q.slots[2]     <= cfg_wdata;
				dam_pkg::REG_SLOTS_D:      cfg_q.slots[3]     <= cfg_wdata;
				dam_pkg::REG_SLOTS_E:      cfg_q.slots[4]     <= cfg_wdata;
				dam_pkg::REG_TAPS_LOW:     cfg_q.taps[0]      <= cfg_wdata[53:0];
				dam_pkg::REG_TAPS_HIGH:    cfg_q.taps[1]      <= cfg_wdata[53:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hdl/dam_decode.sv */
// ----------------------------------------------------------------------------
// dam_decode: address field gather and bank hash
// Picks each field bit from its configured address position, XORs bank and
// bank group with hash taps, and forms the flat bank index and range flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dam_decode (
	input  dam_pkg::cfg_t                        cfg,
	input  wire logic [dam_pkg::ADDR_BITS-1:0]   addr,
	output dam_pkg::res_t                        res
);

	logic [dam_pkg::NUM_SLOTS-1:0]  sb;
	logic [dam_pkg::HASH_TAPS-1:0]  tb;
	logic [dam_pkg::FW_W-1:0]       wfld [dam_pkg::NUM_FIELDS];
	logic [dam_pkg::MAX_FW-1:0]     vals [dam_pkg::NUM_FIELDS];
	logic [dam_pkg::TOTAL_W-1:0]    total;
	logic                           hash_en;
	logic [1:0]                     bank_h;
	logic [2:0]                     bg_h;
	logic [3:0]                     sh_bg;
	logic [3:0]                     sh_cid;
	logic [3:0]                     sh_rank;

	// Read the address bit at every slot position
	for (genvar k = 0; k < dam_pkg::NUM_SLOTS; k++) begin : g_slot
		assign sb[k] = dam_pkg::bit_at(addr,
			cfg.slots[k / dam_pkg::SLOTS_PER_REG]
				[dam_pkg::POS_W*(k % dam_pkg::SLOTS_PER_REG) +: dam_pkg::POS_W]);
	end

	// Read the address bit at every hash tap position
	for (genvar t = 0; t < dam_pkg::HASH_TAPS; t++) begin : g_tap
		assign tb[t] = dam_pkg::bit_at(addr,
			cfg.taps[t / dam_pkg::TAPS_PER_REG]
				[dam_pkg::POS_W*(t % dam_pkg::TAPS_PER_REG) +: dam_pkg::POS_W]);
	end

	// Saturate widths and gather field bits below each width
	always_comb begin
		for (int f = 0; f < dam_pkg::NUM_FIELDS; f++) begin
			if (cfg.field_widths[dam_pkg::FW_W*f +: dam_pkg::FW_W] >
					dam_pkg::FW_W'(dam_pkg::SLOT_MAX[f])) begin
				wfld[f] = dam_pkg::FW_W'(dam_pkg::SLOT_MAX[f]);
			end else begin
				wfld[f] = cfg.field_widths[dam_pkg::FW_W*f +: dam_pkg::FW_W];
			end
			vals[f] = '0;
			for (int i = 0; i < dam_pkg::MAX_FW; i++) begin
				if (i < dam_pkg::SLOT_MAX[f]) begin
					vals[f][i] = sb[dam_pkg::SLOT_BASE[f] + i] &&
						(dam_pkg::FW_W'(i) < wfld[f]);
				end
			end
		end
	end

	// Hash bank and bank group bits that lie below the field width
	assign hash_en = cfg.field_widths[dam_pkg::HASH_EN_BIT];

	always_comb begin
		bank_h = vals[dam_pkg::F_BANK][1:0];
		bg_h   = vals[dam_pkg::F_BG][2:0];
		if (hash_en) begin
			bank_h[0] = bank_h[0] ^ ((wfld[dam_pkg::F_BANK] > 5'd0) &&
				(tb[0] ^ tb[1] ^ tb[2]));
			bank_h[1] = bank_h[1] ^ ((wfld[dam_pkg::F_BANK] > 5'd1) &&
				(tb[3] ^ tb[4] ^ tb[5]));
			bg_h[0] = bg_h[0] ^ ((wfld[dam_pkg::F_BG] > 5'd0) &&
				(tb[6] ^ tb[7] ^ tb[8] ^ tb[9]));
			bg_h[1] = bg_h[1] ^ ((wfld[dam_pkg::F_BG] > 5'd1) &&
				(tb[10] ^ tb[11] ^ tb[12] ^ tb[13]));
			bg_h[2] = bg_h[2] ^ ((wfld[dam_pkg::F_BG] > 5'd2) &&
				(tb[14] ^ tb[15] ^ tb[16] ^ tb[17]));
		end
	end

	// Sum widths for the range check
	always_comb begin
		total = '0;
		for (int f = 0; f < dam_pkg::NUM_FIELDS; f++) begin
			total = total + dam_pkg::TOTAL_W'(wfld[f]);
		end
	end

	// Shift amounts for the flat bank index (widths of bank, group, chip ID)
	assign sh_bg   = wfld[dam_pkg::F_BANK][3:0];
	assign sh_cid  = sh_bg + wfld[dam_pkg::F_BG][3:0];
	assign sh_rank = sh_cid + wfld[dam_pkg::F_CID][3:0];

	// Assemble the result
	always_comb begin
		res.channel        = vals[dam_pkg::F_CHANNEL][1:0];
		res.sub_ch         = vals[dam_pkg::F_SUB][0];
		res.pseudo_ch      = vals[dam_pkg::F_PSEUDO][0];
		res.rank           = vals[dam_pkg::F_RANK][1:0];
		res.chip_id        = vals[dam_pkg::F_CID][2:0];
		res.bank_group     = bg_h;
		res.bank           = bank_h;
		res.row            = vals[dam_pkg::F_ROW][17:0];
		res.column         = vals[dam_pkg::F_COLUMN][10:0];
		res.byte_offset    = vals[dam_pkg::F_BYTE][6:0];
		res.flat_bank      = {8'd0, bank_h}
			| ({7'd0, bg_h} << sh_bg)
			| ({7'd0, vals[dam_pkg::F_CID][2:0]} << sh_cid)
			| ({8'd0, vals[dam_pkg::F_RANK][1:0]} << sh_rank);
		res.out_of_range   = (addr >> total) != '0;
	end

endmodule

`default_nettype wire
